// ===== hdl/vbusd_pkg.sv =====
// ----------------------------------------------------------------------------
// vbusd_pkg: shared types and constants of the 2x upscale blitter
// Register indexes, geometry constants, and the structs that travel between
// the configuration block, the source tracker and the write expander.
// ----------------------------------------------------------------------------
package vbusd_pkg;

  localparam int unsigned CFG_W  = 12;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned PIX_W  = 32;

  // Register indexes on the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_SOURCE_WIDTH    = 3'd0,
    REG_SOURCE_HEIGHT   = 3'd1,
    REG_SMALL_VIDEO     = 3'd2,
    REG_SCREEN_WIDTH    = 3'd3,
    REG_SCREEN_HEIGHT   = 3'd4,
    REG_SUBTITLE_TOP    = 3'd5,
    REG_SUBTITLE_BOTTOM = 3'd6
  } reg_index_t;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST    = 12'd320;
  localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST   = 12'd240;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST    = 12'd640;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST   = 12'd480;
  localparam logic [CFG_W-1:0] SUBTITLE_TOP_RST    = 12'd1;
  localparam logic [CFG_W-1:0] SUBTITLE_BOTTOM_RST = 12'd0;

  // Geometry
  localparam logic [CFG_W-1:0] MAX_DIM     = 12'd2048;
  localparam logic [CFG_W-1:0] HALF_PLAY_W = 12'd320;
  localparam logic [CFG_W-1:0] HALF_PLAY_H = 12'd240;
  localparam logic [8:0]       PLAY_H      = 9'd480;
  localparam logic [12:0]      BAND_ABOVE  = 13'd10;
  localparam logic [12:0]      BAND_BELOW  = 13'd6;
  localparam logic [CFG_W-1:0] BAND_COL_LO = 12'd14;
  localparam logic [CFG_W-1:0] BAND_COL_HI = 12'd624;
  localparam logic [PIX_W-1:0] DARK_MASK   = 32'h007f7f7f;
  localparam logic [DIM_W-1:0] ROW_MAX     = 11'h7ff;

  // Placement and band limits, derived from the registers
  typedef struct packed {
    logic             scale2;  // doubling on
    logic [10:0]      bx;      // left margin
    logic [9:0]       by;      // top margin
    logic [CFG_W-1:0] sw_eff;  // screen width clamped to MAX_DIM
    logic [CFG_W-1:0] sh_eff;  // screen height clamped to MAX_DIM
    logic             boxes;   // subtitle band on
    logic [10:0]      ys;      // first band row, drawn space
    logic [8:0]       ye;      // row after the band, drawn space
  } geom_t;

  // One source pixel with its position
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic             in_frame;
  } item_t;

endpackage

// ===== hdl/vbusd_cfg.sv =====
// ----------------------------------------------------------------------------
// vbusd_cfg: configuration registers and derived placement
// Holds the seven registers and registers the margins, clamps and band
// limits that follow from them.
// ----------------------------------------------------------------------------
module vbusd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [vbusd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vbusd_pkg::CFG_W-1:0]   cfg_data,
  output logic [vbusd_pkg::CFG_W-1:0]   source_width,
  output logic [vbusd_pkg::CFG_W-1:0]   source_height,
  output vbusd_pkg::geom_t              geom
);

  logic                        small_video;
  logic [vbusd_pkg::CFG_W-1:0] screen_width;
  logic [vbusd_pkg::CFG_W-1:0] screen_height;
  logic [vbusd_pkg::CFG_W-1:0] subtitle_top;
  logic [vbusd_pkg::CFG_W-1:0] subtitle_bottom;

  vbusd_pkg::geom_t geom_next;
  logic [12:0]      draw_w;
  logic [12:0]      draw_h;
  logic [12:0]      diff_w;
  logic [12:0]      diff_h;
  logic [12:0]      top_m;
  logic [12:0]      bot_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width    <= vbusd_pkg::SOURCE_WIDTH_RST;
      source_height   <= vbusd_pkg::SOURCE_HEIGHT_RST;
      small_video     <= 1'b0;
      screen_width    <= vbusd_pkg::SCREEN_WIDTH_RST;
      screen_height   <= vbusd_pkg::SCREEN_HEIGHT_RST;
      subtitle_top    <= vbusd_pkg::SUBTITLE_TOP_RST;
      subtitle_bottom <= vbusd_pkg::SUBTITLE_BOTTOM_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        vbusd_pkg::REG_SOURCE_WIDTH:    source_width    <= cfg_data;
        vbusd_pkg::REG_SOURCE_HEIGHT:   source_height   <= cfg_data;
        vbusd_pkg::REG_SMALL_VIDEO:     small_video     <= cfg_data[0];
        vbusd_pkg::REG_SCREEN_WIDTH:    screen_width    <= cfg_data;
        vbusd_pkg::REG_SCREEN_HEIGHT:   screen_height   <= cfg_data;
        vbusd_pkg::REG_SUBTITLE_TOP:    subtitle_top    <= cfg_data;
        vbusd_pkg::REG_SUBTITLE_BOTTOM: subtitle_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    geom_next.scale2 = (source_width <= vbusd_pkg::HALF_PLAY_W) &&
                       (source_height <= vbusd_pkg::HALF_PLAY_H) && !small_video;
    draw_w = geom_next.scale2 ? {source_width, 1'b0} : {1'b0, source_width};
    draw_h = geom_next.scale2 ? {source_height, 1'b0} : {1'b0, source_height};
    diff_w = {1'b0, screen_width} - draw_w;
    diff_h = {1'b0, screen_height} - draw_h;
    // center horizontally, a quarter of the margin on top
    geom_next.bx = ({1'b0, screen_width} > draw_w) ? diff_w[11:1] : '0;
    geom_next.by = ({1'b0, screen_height} > draw_h) ? diff_h[11:2] : '0;
    geom_next.sw_eff = (screen_width > vbusd_pkg::MAX_DIM) ? vbusd_pkg::MAX_DIM
                                                           : screen_width;
    geom_next.sh_eff = (screen_height > vbusd_pkg::MAX_DIM) ? vbusd_pkg::MAX_DIM
                                                            : screen_height;
    geom_next.boxes = !small_video &&
                      ($signed(subtitle_top) <= $signed(subtitle_bottom));
    top_m = {subtitle_top[11], subtitle_top} - vbusd_pkg::BAND_ABOVE;
    bot_p = {subtitle_bottom[11], subtitle_bottom} + vbusd_pkg::BAND_BELOW;
    geom_next.ys = top_m[12] ? '0 : top_m[10:0];
    if (bot_p[12]) begin
      geom_next.ye = '0;
    end else if (bot_p[11:0] > {3'b000, vbusd_pkg::PLAY_H}) begin
      geom_next.ye = vbusd_pkg::PLAY_H;
    end else begin
      geom_next.ye = bot_p[8:0];
    end
  end

  always_ff @(posedge clk) begin
    geom <= geom_next;
  end

endmodule

// ===== hdl/vbusd_track.sv =====
// ----------------------------------------------------------------------------
// vbusd_track: input register and source position counters
// Takes one source pixel per transfer, tags it with its column and row and
// advances the raster position.
// ----------------------------------------------------------------------------
module vbusd_track (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vbusd_pkg::PIX_W-1:0]   pixel,
  input  logic                          frame_start,
  input  logic [vbusd_pkg::CFG_W-1:0]   source_width,
  input  logic [vbusd_pkg::CFG_W-1:0]   source_height,
  output logic                          a_valid,
  output vbusd_pkg::item_t              a_item,
  input  logic                          a_take
);

  logic [vbusd_pkg::DIM_W-1:0] source_column;
  logic [vbusd_pkg::DIM_W-1:0] source_row;
  logic [vbusd_pkg::DIM_W-1:0] cur_col;
  logic [vbusd_pkg::DIM_W-1:0] cur_row;
  logic [vbusd_pkg::DIM_W-1:0] source_column_next;
  logic [vbusd_pkg::DIM_W-1:0] source_row_next;
  logic [vbusd_pkg::CFG_W-1:0] col_inc;
  logic                        wrap;
  logic                        in_fire;

  assign in_ready = !a_valid || a_take;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cur_col = frame_start ? '0 : source_column;
    cur_row = frame_start ? '0 : source_row;
    col_inc = {1'b0, cur_col} + 12'd1;
    // also covers a column already past the width
    wrap    = col_inc >= source_width;
    source_column_next = wrap ? '0 : col_inc[vbusd_pkg::DIM_W-1:0];
    source_row_next    = (wrap && cur_row != vbusd_pkg::ROW_MAX) ? cur_row + 11'd1
                                                                 : cur_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
      a_valid       <= 1'b0;
    end else begin
      if (in_fire) begin
        source_column <= source_column_next;
        source_row    <= source_row_next;
        a_valid       <= 1'b1;
      end else if (a_take) begin
        a_valid       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item.pixel    <= pixel;
      a_item.col      <= cur_col;
      a_item.row      <= cur_row;
      a_item.in_frame <= ({1'b0, cur_col} < source_width) &&
                         ({1'b0, cur_row} < source_height);
    end
  end

  a_wrap_clears_col: assert property (@(posedge clk) disable iff (rst)
    !rst && in_fire && wrap |=> source_column == '0)
    else $error("column not cleared after end of line");

  a_row_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst && in_fire && !frame_start |=> source_row >= $past(source_row))
    else $error("row moved back without frame start");

  a_item_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_take |=> a_valid && $stable(a_item))
    else $error("held item lost or changed");

endmodule

// ===== hdl/vbusd_expand.sv =====
// ----------------------------------------------------------------------------
// vbusd_expand: write expander and output register
// Turns one tagged pixel into up to four screen writes, darkens those in
// the subtitle band and hands them out one per cycle, unless stalled.
// ----------------------------------------------------------------------------
module vbusd_expand (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          a_valid,
  input  vbusd_pkg::item_t              a_item,
  output logic                          a_take,
  input  vbusd_pkg::geom_t              geom,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vbusd_pkg::DIM_W-1:0]   screen_row,
  output logic [vbusd_pkg::DIM_W-1:0]   screen_col,
  output logic [vbusd_pkg::PIX_W-1:0]   out_pixel,
  output logic                          last
);

  // write k = 2*dy + dx; bit order gives top pair left, right, then bottom
  logic [3:0]                  mask;
  logic [3:0]                  dark;
  logic [vbusd_pkg::PIX_W-1:0] pix;
  logic [vbusd_pkg::DIM_W-1:0] row_lo;
  logic [vbusd_pkg::DIM_W-1:0] row_hi;
  logic [vbusd_pkg::DIM_W-1:0] col_lo;
  logic [vbusd_pkg::DIM_W-1:0] col_hi;

  logic [3:0]  mask_next;
  logic [3:0]  dark_next;
  logic [3:0]  pick;
  logic [3:0]  rest;
  logic [1:0]  sel;
  logic        b_valid;
  logic        room;
  logic        b_emit;
  logic        b_free;
  logic [11:0] j0;
  logic [11:0] i0;
  logic [11:0] j     [2];
  logic [11:0] i     [2];
  logic [12:0] srow  [2];
  logic [12:0] scol  [2];
  logic [1:0]  row_ok;
  logic [1:0]  col_ok;
  logic [1:0]  dark_row;
  logic [1:0]  dark_col;

  assign b_valid = |mask;
  assign room    = !out_valid || out_ready;
  assign b_emit  = b_valid && room;
  assign pick    = mask & (~mask + 4'd1);
  assign rest    = mask & ~pick;
  assign b_free  = !b_valid || (b_emit && rest == 4'd0);
  assign a_take  = a_valid && b_free;

  always_comb begin
    j0 = geom.scale2 ? {a_item.row, 1'b0} : {1'b0, a_item.row};
    i0 = geom.scale2 ? {a_item.col, 1'b0} : {1'b0, a_item.col};
    for (int d = 0; d < 2; d++) begin
      j[d]        = j0 + 12'(d);
      i[d]        = i0 + 12'(d);
      srow[d]     = 13'(geom.by) + 13'(j[d]);
      scol[d]     = 13'(geom.bx) + 13'(i[d]);
      row_ok[d]   = srow[d] < {1'b0, geom.sh_eff};
      col_ok[d]   = scol[d] < {1'b0, geom.sw_eff};
      dark_row[d] = geom.boxes && (j[d] >= {1'b0, geom.ys}) &&
                    (j[d] < {3'b000, geom.ye});
      dark_col[d] = (i[d] > vbusd_pkg::BAND_COL_LO) && (i[d] < vbusd_pkg::BAND_COL_HI);
    end
    for (int k = 0; k < 4; k++) begin
      mask_next[k] = a_item.in_frame && row_ok[k/2] && col_ok[k%2] &&
                     (geom.scale2 || k == 0);
      dark_next[k] = dark_row[k/2] && dark_col[k%2];
    end
    case (pick)
      4'b0001: sel = 2'd0;
      4'b0010: sel = 2'd1;
      4'b0100: sel = 2'd2;
      default: sel = 2'd3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (a_take) begin
      mask <= mask_next;
    end else if (b_emit) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      dark   <= dark_next;
      pix    <= a_item.pixel;
      row_lo <= srow[0][vbusd_pkg::DIM_W-1:0];
      row_hi <= srow[1][vbusd_pkg::DIM_W-1:0];
      col_lo <= scol[0][vbusd_pkg::DIM_W-1:0];
      col_hi <= scol[1][vbusd_pkg::DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_emit) begin
      screen_row <= sel[1] ? row_hi : row_lo;
      screen_col <= sel[0] ? col_hi : col_lo;
      out_pixel  <= dark[sel] ? ((pix >> 1) & vbusd_pkg::DARK_MASK) : pix;
      last       <= (rest == 4'd0);
    end
  end

  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> $onehot(pick))
    else $error("write select not one-hot");

  a_mask_advance: assert property (@(posedge clk) disable iff (rst)
    b_emit && rest != 4'd0 |=> mask == $past(rest))
    else $error("pending writes not advanced in order");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !b_valid && !out_valid |=> !out_valid)
    else $error("write appeared with nothing pending");

endmodule

// ===== hdl/video_blit_upscale_subtitle_darken_top.sv =====
// ----------------------------------------------------------------------------
// video_blit_upscale_subtitle_darken_top: 2x upscale blitter with subtitle band
// Source XRGB pixels in, screen writes (row, column, pixel) out.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one source pixel per transfer
//   in raster order; frame_start on a transfer restarts column and row at 0.
//   The output channel (out_valid/out_ready) gives one screen write per
//   transfer. A pixel gives up to four writes when the frame is doubled
//   (source at most 320x240, small_video off), one otherwise, or none when
//   it lies outside the frame or all its writes fall off the screen. last
//   marks the final write of a pixel.
//   Each write passes the input register, the expander and the output
//   register. Throughput, while the receiver keeps up: one pixel per cycle
//   undoubled; doubled, one write per cycle on the single output port.
//   The input register takes the next pixel while the expander still works.
//   When the receiver stalls, the output register holds its write, the
//   expander holds its pending writes and the input side backs up one pixel.
//   Reset clears the position counters, empties the pipeline and loads the
//   registers with their reset values. Write the configuration port only
//   while no pixel is in flight.
// ----------------------------------------------------------------------------
module video_blit_upscale_subtitle_darken_top (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          cfg_write,
  input  logic [vbusd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vbusd_pkg::CFG_W-1:0]   cfg_data,
  // source pixels
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vbusd_pkg::PIX_W-1:0]   pixel,
  input  logic                          frame_start,
  // screen writes
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vbusd_pkg::DIM_W-1:0]   screen_row,
  output logic [vbusd_pkg::DIM_W-1:0]   screen_col,
  output logic [vbusd_pkg::PIX_W-1:0]   out_pixel,
  output logic                          last
);

  logic [vbusd_pkg::CFG_W-1:0] source_width;
  logic [vbusd_pkg::CFG_W-1:0] source_height;
  vbusd_pkg::geom_t            geom;
  logic                        a_valid;
  vbusd_pkg::item_t            a_item;
  logic                        a_take;

  // Registers and derived placement; the derived values are registered from
  // the configuration registers.
  vbusd_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .source_width  (source_width),
    .source_height (source_height),
    .geom          (geom)
  );

  // Input register: tag each pixel with its raster position.
  vbusd_track u_track (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel         (pixel),
    .frame_start   (frame_start),
    .source_width  (source_width),
    .source_height (source_height),
    .a_valid       (a_valid),
    .a_item        (a_item),
    .a_take        (a_take)
  );

  // Expander: build a pixel's writes once, send one a cycle unless stalled.
  vbusd_expand u_expand (
    .clk        (clk),
    .rst        (rst),
    .a_valid    (a_valid),
    .a_item     (a_item),
    .a_take     (a_take),
    .geom       (geom),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .screen_row (screen_row),
    .screen_col (screen_col),
    .out_pixel  (out_pixel),
    .last       (last)
  );

endmodule

// ===== bench/video_blit_upscale_subtitle_darken_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_blit_upscale_subtitle_darken_top_tb: self-checking bench of the blitter
// Streams source pixels through the valid/ready input, predicts every screen
// write (doubling, centering, clipping, subtitle darkening, position counters)
// and checks each write on the output port in order against the prediction.
// ----------------------------------------------------------------------------
module video_blit_upscale_subtitle_darken_top_tb;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 11;
  // Slowest legal run: up to 340 pixels, up to four writes each, stalls on both
  // sides and one long hold; the limit allows far more.
  localparam int RUN_LIMIT      = 500000;
  localparam int SETTLE_CYCLES  = 8;    // time for the pipeline to settle, with margin
  localparam int HOLD_CYCLES    = 300;  // long receiver hold-off

  // Geometry of the block
  localparam int          SCREEN_CLAMP   = 2048;
  localparam int          DOUBLE_MAX_W   = 320;
  localparam int          DOUBLE_MAX_H   = 240;
  localparam int          BAND_LEAD      = 10;
  localparam int          BAND_TRAIL     = 6;
  localparam int          BAND_MAX_ROW   = 480;
  localparam int          BAND_FIRST_COL = 14;
  localparam int          BAND_END_COL   = 624;
  localparam logic [31:0] HALF_MASK      = 32'h007f7f7f;
  localparam int          ROW_CEIL       = 2047;

  typedef struct packed {
    logic [10:0] row;
    logic [10:0] col;
    logic [31:0] pix;
    logic        last;
  } screen_write_t;

  // DUT inputs start at known values
  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  vbusd_pkg::reg_index_t cfg_index   = vbusd_pkg::REG_SOURCE_WIDTH;
  logic [11:0]           cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic [31:0]           pixel       = '0;
  logic                  frame_start = 1'b0;
  logic                  out_ready   = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [10:0] screen_row;
  logic [10:0] screen_col;
  logic [31:0] out_pixel;
  logic        last;

  // Shadow copy of the registers and the position counters
  logic [11:0]        src_w_q   = 12'd320;
  logic [11:0]        src_h_q   = 12'd240;
  logic               small_q   = 1'b0;
  logic [11:0]        scr_w_q   = 12'd640;
  logic [11:0]        scr_h_q   = 12'd480;
  logic signed [11:0] sub_top_q = 12'sd1;
  logic signed [11:0] sub_bot_q = 12'sd0;
  logic [10:0]        src_col_q = '0;
  logic [10:0]        src_row_q = '0;

  screen_write_t pending_writes[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            idle_pct       = 20;
  bit            hold_req       = 1'b0;

  video_blit_upscale_subtitle_darken_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .screen_row  (screen_row),
    .screen_col  (screen_col),
    .out_pixel   (out_pixel),
    .last        (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Work out the writes one source pixel causes, queue them, and advance the
  // column/row counters exactly as the block does.
  task automatic expand_pixel(input logic [31:0] value, input logic restart);
    int col, row, src_w, src_h, scr_w, scr_h, clip_w, clip_h;
    int scale, bx, by, top, bot, ys, ye, j, i, n;
    bit band_on, dark_row;
    screen_write_t blk[4];
    src_w = src_w_q;
    src_h = src_h_q;
    scr_w = scr_w_q;
    scr_h = scr_h_q;
    top   = sub_top_q;   // sign-extends
    bot   = sub_bot_q;
    if (restart) begin
      src_col_q = '0;
      src_row_q = '0;
    end
    col    = src_col_q;
    row    = src_row_q;
    clip_w = (scr_w > SCREEN_CLAMP) ? SCREEN_CLAMP : scr_w;
    clip_h = (scr_h > SCREEN_CLAMP) ? SCREEN_CLAMP : scr_h;
    n      = 0;
    // Pixels outside the frame (extra pixels, or a frame shrunk under us)
    // produce nothing but still move the counters.
    if (col < src_w && row < src_h) begin
      scale = (src_w <= DOUBLE_MAX_W && src_h <= DOUBLE_MAX_H && !small_q) ? 2 : 1;
      // Center horizontally, a quarter of the margin on top; clamp at 0.
      bx = (scr_w > src_w * scale) ? (scr_w - src_w * scale) / 2 : 0;
      by = (scr_h > src_h * scale) ? (scr_h - src_h * scale) / 4 : 0;
      band_on = !small_q && top <= bot;
      ys = (top - BAND_LEAD < 0) ? 0 : top - BAND_LEAD;
      ye = (bot + BAND_TRAIL > BAND_MAX_ROW) ? BAND_MAX_ROW : bot + BAND_TRAIL;
      // Top pair left then right, then bottom pair; drop off-screen writes.
      for (int dy = 0; dy < scale; dy++) begin
        j = row * scale + dy;
        dark_row = band_on && j >= ys && j < ye;
        if (by + j < clip_h) begin
          for (int dx = 0; dx < scale; dx++) begin
            i = col * scale + dx;
            if (bx + i < clip_w) begin
              blk[n].row  = 11'(by + j);
              blk[n].col  = 11'(bx + i);
              blk[n].pix  = (dark_row && i > BAND_FIRST_COL && i < BAND_END_COL) ?
                            ((value >> 1) & HALF_MASK) : value;
              blk[n].last = 1'b0;
              n++;
            end
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      blk[k].last = (k == n - 1);
      pending_writes.push_back(blk[k]);
    end
    // Wrap the column at the frame width; saturate the row.
    if (col >= src_w || col + 1 >= src_w) begin
      src_col_q = '0;
      if (src_row_q < ROW_CEIL) src_row_q++;
    end else begin
      src_col_q = 11'(col + 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Compare every write transfer with the oldest queued prediction.
  always @(posedge clk) begin : check_writes
    screen_write_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("write with nothing pending: row %0d col %0d pixel %h",
                                  screen_row, screen_col, out_pixel));
      end else begin
        want = pending_writes.pop_front();
        if (screen_row !== want.row)
          report_mismatch($sformatf("screen_row %0d, want %0d", screen_row, want.row));
        if (screen_col !== want.col)
          report_mismatch($sformatf("screen_col %0d, want %0d", screen_col, want.col));
        if (out_pixel !== want.pix)
          report_mismatch($sformatf("out_pixel %h, want %h (row %0d col %0d)",
                                    out_pixel, want.pix, want.row, want.col));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, want %b (row %0d col %0d)",
                                    last, want.last, want.row, want.col));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver side: random back-pressure, or one long counted hold on request
  // --------------------------------------------------------------------------
  initial begin : sink_side
    int held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // Hold off long enough for the block to fill and stall its input.
        out_ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one pixel and hold it until the transfer; idle at random first.
  task automatic send_pixel(input logic [31:0] value, input logic restart);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel       <= value;
    frame_start <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expand_pixel(value, restart);
  endtask

  // Drop valid, let every predicted write drain, then let the pipeline settle
  // (a trailing pixel may cause no write at all).
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input vbusd_pkg::reg_index_t which, input int value);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value[11:0];
    @(posedge clk);
  endtask

  // Load all seven registers while the block is idle.
  task automatic configure(input int src_w, input int src_h, input bit small_mode,
                           input int scr_w, input int scr_h,
                           input int sub_top, input int sub_bot);
    wait_idle();
    write_reg(vbusd_pkg::REG_SOURCE_WIDTH, src_w);
    write_reg(vbusd_pkg::REG_SOURCE_HEIGHT, src_h);
    write_reg(vbusd_pkg::REG_SMALL_VIDEO, int'(small_mode));
    write_reg(vbusd_pkg::REG_SCREEN_WIDTH, scr_w);
    write_reg(vbusd_pkg::REG_SCREEN_HEIGHT, scr_h);
    write_reg(vbusd_pkg::REG_SUBTITLE_TOP, sub_top);
    write_reg(vbusd_pkg::REG_SUBTITLE_BOTTOM, sub_bot);
    cfg_write <= 1'b0;
    src_w_q   = src_w[11:0];
    src_h_q   = src_h[11:0];
    small_q   = small_mode;
    scr_w_q   = scr_w[11:0];
    scr_h_q   = scr_h[11:0];
    sub_top_q = sub_top[11:0];
    sub_bot_q = sub_bot[11:0];
  endtask

  function automatic int pick_screen_dim();
    case ($urandom_range(7))
      0:       return SCREEN_CLAMP;
      1:       return 640;
      2:       return $urandom_range(1, SCREEN_CLAMP);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // Mostly near zero so band edges land inside small frames.
  function automatic int pick_text_line();
    if ($urandom_range(4) == 0) return int'($urandom_range(4095)) - 2048;
    return int'($urandom_range(24)) - 12;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: 320x240 doubled onto 640x480, band off.
  task automatic test_reset_state();
    send_pixel(32'hffffffff, 1'b1);
    send_pixel(32'h00000000, 1'b0);
    send_pixel(32'ha5a5a5a5, 1'b0);
  endtask

  // Doubled 10x2 frame on a 17x3 screen: right edge drops part of a block and
  // then whole blocks, bottom edge drops the lower pair; band darkens row 2.
  // Stop mid-row so the next test meets a column beyond the new width.
  task automatic test_partial_clip();
    configure(10, 2, 1'b0, 17, 3, 12, 12);
    for (int k = 0; k < 15; k++) send_pixel($urandom, k == 0);
  endtask

  // Smallest and largest sizes, extreme subtitle lines, extra pixels.
  task automatic test_extreme_sizes();
    configure(1, 1, 1'b0, 1, 1, -2048, 2047);
    send_pixel(32'h12345678, 1'b0);   // column beyond width: no write, wrap
    send_pixel(32'hffffffff, 1'b1);
    send_pixel(32'h87654321, 1'b0);   // past the last row: no write
    send_pixel(32'h00000000, 1'b1);
    configure(2048, 2048, 1'b1, 2048, 2048, 2047, -2048);
    send_pixel(32'h80000001, 1'b1);
    send_pixel(32'h7ffffffe, 1'b0);
    // Tiny doubled frame on a huge screen: large margins both ways.
    configure(2, 1, 1'b0, 2048, 2048, 0, 0);
    send_pixel(32'h00ff00ff, 1'b1);
    send_pixel(32'hff00ff00, 1'b0);
  endtask

  // Receiver holds off for a long stretch while pixels keep coming.
  task automatic test_output_stall();
    configure(4, 3, 1'b0, 640, 480, 0, 20);
    hold_req = 1'b1;
    for (int k = 0; k < 24; k++) send_pixel($urandom, k == 0);
  endtask

  // No idling on either side: doubled, then one write per pixel in the frame.
  task automatic test_back_to_back();
    idle_pct = 0;
    configure(5, 3, 1'b0, 40, 20, -10, 8);
    for (int k = 0; k < 20; k++) send_pixel($urandom, k == 0);
    configure(5, 3, 1'b1, 40, 20, -10, 8);
    for (int k = 0; k < 20; k++) send_pixel($urandom, k == 0);
    wait_idle();
    idle_pct = 20;
  endtask

  // Start of a doubled row of 320: crosses the left band column limit.
  task automatic test_band_columns();
    configure(320, 1, 1'b0, 640, 480, int'($urandom_range(14)) - 4, $urandom_range(10, 40));
    for (int k = 0; k < 40; k++) send_pixel($urandom, k == 0);
  endtask

  // Random geometry per phase; mostly whole frames, some restarts mid-frame,
  // extra pixels, and phases that carry on from the previous position.
  task automatic test_random_frames();
    int src_w, src_h, count;
    repeat (6) begin
      case ($urandom_range(9))
        7:       src_w = 320;
        8:       src_w = 321;
        9:       src_w = 2048;
        default: src_w = $urandom_range(1, 6);
      endcase
      case ($urandom_range(7))
        0:       src_h = 240;
        1:       src_h = 241;
        2:       src_h = 2048;
        default: src_h = $urandom_range(1, 4);
      endcase
      configure(src_w, src_h, $urandom_range(3) == 0, pick_screen_dim(), pick_screen_dim(),
                pick_text_line(), pick_text_line());
      count = (src_w * src_h > 24) ? 24 : src_w * src_h;
      count += $urandom_range(3);
      for (int k = 0; k < count; k++)
        send_pixel($urandom, (k == 0) ? ($urandom_range(3) != 0) : ($urandom_range(19) == 0));
    end
  endtask

  // 16x2048 undoubled on a 2048x2048 screen: band bottom clamps at 480 and
  // the band top clamps at 0, so the first rows are darkened.
  task automatic test_tall_frame();
    configure(16, 2048, 1'b0, 2048, 2048, 5, 2047);
    for (int k = 0; k < 48; k++) send_pixel($urandom, k == 0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_partial_clip();
    test_extreme_sizes();
    test_output_stall();
    test_back_to_back();
    test_band_columns();
    test_random_frames();
    test_tall_frame();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/vbusd_pkg.sv
hdl/vbusd_cfg.sv
hdl/vbusd_track.sv
hdl/vbusd_expand.sv
hdl/video_blit_upscale_subtitle_darken_top.sv
bench/video_blit_upscale_subtitle_darken_top_tb.sv
